/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Each check is sampled on the rising clock and switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/crc8pr_pkg.sv */
package crc8pr_pkg;

    // Frame positions held in the store; position 6 and later are never read.
    localparam int STORE_DEPTH = 6;
    localparam int STORE_AW    = 3;
    localparam int LONG_LEN    = 7;
    localparam int LEN_W       = 5;
    localparam logic [7:0] CRC_TOP = 8'h80;

    // Register map, by word index.
    typedef enum logic [1:0] {
        REG_NODE_ADDRESS     = 2'd0,
        REG_FRAME_END_BYTE   = 2'd1,
        REG_CHECK_POLYNOMIAL = 2'd2,
        REG_CHECK_INITIAL    = 2'd3
    } reg_index_t;

    // One closed frame on its way through the check pipeline.
    typedef struct packed {
        logic [LEN_W-1:0] frame_length;
        logic             long_form;
        logic [7:0]       master_status;
        logic [7:0]       target_address;
        logic [7:0]       instruction_code;
        logic [7:0]       drive_speed;
        logic [7:0]       motor_select_direction;
        logic [7:0]       received_check;
        logic             frame_overflow;
        logic [7:0]       crc;
        logic             crc_stop;
    } frame_t;

    // One byte of MSB-first CRC-8.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b,
                                            input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Feed one covered byte; a zero byte ends coverage for the rest of the frame.
    function automatic frame_t crc_stage(input frame_t f, input logic [7:0] b,
                                         input logic [7:0] poly);
        frame_t r;
        r = f;
        if (!f.crc_stop && b != 8'h00) begin
            r.crc = crc_feed(f.crc, b, poly);
        end else begin
            r.crc_stop = 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/crc8_packet_receiver.sv */
// Channel  | Handshake            | Payload
// s_       | s_valid / s_ready    | s_rx_byte
// m_       | m_valid / m_ready    | frame fields, check and address results
// cfg      | psel/penable/pready  | paddr, pwdata, prdata
//
// One byte is taken per cycle while s_ready is high. A byte that closes a frame
// enters a four-register check pipeline (snapshot, two CRC byte steps, final CRC
// step with compare) that ends at m_. s_ready falls only when that pipeline is full
// and the result register is stalled. Reset is synchronous, active low, and clears
// the frame store, counters, pipeline valids and config registers to their defaults.
`include "assert_macros.svh"

module crc8_packet_receiver #(
    parameter int MAX_FRAME = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_frame_length,
    output logic        m_long_form,
    output logic [7:0]  m_master_status,
    output logic [7:0]  m_target_address,
    output logic [7:0]  m_instruction_code,
    output logic [7:0]  m_drive_speed,
    output logic [7:0]  m_motor_select_direction,
    output logic [7:0]  m_received_check,
    output logic [7:0]  m_computed_check,
    output logic        m_check_ok,
    output logic        m_for_this_node,
    output logic        m_frame_overflow,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    // Configuration registers
    logic [7:0] node_address_reg;
    logic [7:0] frame_end_byte_reg;
    logic [7:0] check_polynomial_reg;
    logic [7:0] check_initial_reg;

    crc8pr_pkg::reg_index_t cfg_index;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = crc8pr_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_address_reg     <= 8'd16;
            frame_end_byte_reg   <= 8'd192;
            check_polynomial_reg <= 8'd7;
            check_initial_reg    <= 8'd0;
        end else if (cfg_write) begin
            case (cfg_index)
                crc8pr_pkg::REG_NODE_ADDRESS:     node_address_reg     <= pwdata[7:0];
                crc8pr_pkg::REG_FRAME_END_BYTE:   frame_end_byte_reg   <= pwdata[7:0];
                crc8pr_pkg::REG_CHECK_POLYNOMIAL: check_polynomial_reg <= pwdata[7:0];
                crc8pr_pkg::REG_CHECK_INITIAL:    check_initial_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            crc8pr_pkg::REG_NODE_ADDRESS:     prdata = {24'd0, node_address_reg};
            crc8pr_pkg::REG_FRAME_END_BYTE:   prdata = {24'd0, frame_end_byte_reg};
            crc8pr_pkg::REG_CHECK_POLYNOMIAL: prdata = {24'd0, check_polynomial_reg};
            crc8pr_pkg::REG_CHECK_INITIAL:    prdata = {24'd0, check_initial_reg};
            default:                          prdata = 32'd0;
        endcase
    end

    // Pipeline control: each stage loads when it is empty or its successor loads
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic en1, en2, en3, en_o;

    assign en_o    = !vo_reg || m_ready;
    assign en3     = !v3_reg || en_o;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    logic s_beat;
    assign s_beat = s_valid && s_ready;

    // Frame collection
    logic [7:0]    store_reg [crc8pr_pkg::STORE_DEPTH];
    logic [7:0]    store_next [crc8pr_pkg::STORE_DEPTH];
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [CW-1:0] zero_position_reg, zero_position_next;
    logic          zero_seen_reg, zero_seen_next;
    logic          count_saturated_reg, count_saturated_next;
    logic          frame_close;
    logic [CW-1:0] len_full;
    crc8pr_pkg::frame_t snap;

    assign frame_close = s_beat && (s_rx_byte == frame_end_byte_reg);

    always_comb begin
        store_next           = store_reg;
        zero_seen_next       = zero_seen_reg;
        zero_position_next   = zero_position_reg;
        byte_count_next      = byte_count_reg;
        count_saturated_next = count_saturated_reg;

        if (byte_count_reg < CW'(crc8pr_pkg::STORE_DEPTH)) begin
            store_next[byte_count_reg[crc8pr_pkg::STORE_AW-1:0]] = s_rx_byte;
        end
        if (s_rx_byte == 8'h00 && !zero_seen_reg) begin
            zero_seen_next     = 1'b1;
            zero_position_next = byte_count_reg;
        end
        if (byte_count_reg < CW'(MAX_FRAME)) begin
            byte_count_next = byte_count_reg + CW'(1);
        end else begin
            count_saturated_next = 1'b1;
        end

        // Length stops at the first zero byte, as strlen would
        len_full = zero_seen_next ? zero_position_next : byte_count_next;

        snap.frame_length     = crc8pr_pkg::LEN_W'(len_full);
        snap.long_form        = (len_full == CW'(crc8pr_pkg::LONG_LEN));
        snap.master_status    = store_next[0];
        snap.target_address   = store_next[1];
        snap.instruction_code = store_next[2];
        snap.drive_speed      = snap.long_form ? store_next[3] : 8'h00;
        snap.motor_select_direction = snap.long_form ? store_next[4] : 8'h00;
        snap.received_check   = snap.long_form ? store_next[5] : store_next[3];
        snap.frame_overflow   = count_saturated_next;
        snap.crc              = check_initial_reg;
        snap.crc_stop         = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < crc8pr_pkg::STORE_DEPTH; i++) begin
                store_reg[i] <= 8'h00;
            end
            byte_count_reg      <= '0;
            zero_position_reg   <= '0;
            zero_seen_reg       <= 1'b0;
            count_saturated_reg <= 1'b0;
        end else if (frame_close) begin
            // Start the next frame from a clean store
            for (int i = 0; i < crc8pr_pkg::STORE_DEPTH; i++) begin
                store_reg[i] <= 8'h00;
            end
            byte_count_reg      <= '0;
            zero_position_reg   <= '0;
            zero_seen_reg       <= 1'b0;
            count_saturated_reg <= 1'b0;
        end else if (s_beat) begin
            store_reg           <= store_next;
            byte_count_reg      <= byte_count_next;
            zero_position_reg   <= zero_position_next;
            zero_seen_reg       <= zero_seen_next;
            count_saturated_reg <= count_saturated_next;
        end
    end

    // Check pipeline: one covered byte of CRC per stage
    crc8pr_pkg::frame_t s1_reg, s2_reg, s3_reg, out_reg;
    crc8pr_pkg::frame_t s2_next, s3_next, out_next;
    logic               check_ok_reg, node_hit_reg;

    assign s2_next  = crc8pr_pkg::crc_stage(s1_reg, s1_reg.target_address,
                                            check_polynomial_reg);
    assign s3_next  = crc8pr_pkg::crc_stage(s2_reg, s2_reg.instruction_code,
                                            check_polynomial_reg);
    // Select/direction reads zero in the short form, which ends coverage there
    assign out_next = crc8pr_pkg::crc_stage(s3_reg, s3_reg.motor_select_direction,
                                            check_polynomial_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1)  v1_reg <= frame_close;
            if (en2)  v2_reg <= v1_reg;
            if (en3)  v3_reg <= v2_reg;
            if (en_o) vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) s1_reg <= snap;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
        if (en_o) begin
            out_reg      <= out_next;
            check_ok_reg <= (out_next.received_check == out_next.crc);
            node_hit_reg <= (s3_reg.target_address == node_address_reg);
        end
    end

    assign m_valid                  = vo_reg;
    assign m_frame_length           = out_reg.frame_length;
    assign m_long_form              = out_reg.long_form;
    assign m_master_status          = out_reg.master_status;
    assign m_target_address         = out_reg.target_address;
    assign m_instruction_code       = out_reg.instruction_code;
    assign m_drive_speed            = out_reg.drive_speed;
    assign m_motor_select_direction = out_reg.motor_select_direction;
    assign m_received_check         = out_reg.received_check;
    assign m_computed_check         = out_reg.crc;
    assign m_check_ok               = check_ok_reg;
    assign m_for_this_node          = node_hit_reg;
    assign m_frame_overflow         = out_reg.frame_overflow;

    `ASSERT_SAME(a_long_len, aclk, aresetn, m_valid && m_long_form, m_frame_length == 5'd7)
    `ASSERT_SAME(a_short_zero, aclk, aresetn, m_valid && !m_long_form,
                 m_drive_speed == 8'h00 && m_motor_select_direction == 8'h00)
    `ASSERT_SAME(a_count_cap, aclk, aresetn, 1'b1, byte_count_reg <= CW'(MAX_FRAME))
    `ASSERT_NEXT(a_close_clears, aclk, aresetn, frame_close, byte_count_reg == '0 && !zero_seen_reg)
    `ASSERT_SAME(a_check_cmp, aclk, aresetn, m_valid,
                 m_check_ok == (m_received_check == m_computed_check))

endmodule

/* tb/tb_crc8_packet_receiver.sv */
module tb_crc8_packet_receiver;

    localparam int MAX_FRAME       = 16;
    localparam int KEPT_BYTES      = 7;
    localparam int LONG_FRAME      = 7;
    localparam int DRAIN_CYCLES    = 12;
    localparam int PHASES          = 7;
    localparam int BYTES_PER_PHASE = 90;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DIRECTED_ROWS   = 35;

    typedef struct packed {
        logic [4:0] frame_length;
        logic       long_form;
        logic [7:0] master_status;
        logic [7:0] target_address;
        logic [7:0] instruction_code;
        logic [7:0] drive_speed;
        logic [7:0] motor_select_direction;
        logic [7:0] received_check;
        logic [7:0] computed_check;
        logic       check_ok;
        logic       for_this_node;
        logic       frame_overflow;
    } frame_result_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        crc8pr_pkg::reg_index_t reg_sel;
        logic [7:0]             data;
        logic                   typed;
        frame_result_t          want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_frame_length;
    logic        m_long_form;
    logic [7:0]  m_master_status;
    logic [7:0]  m_target_address;
    logic [7:0]  m_instruction_code;
    logic [7:0]  m_drive_speed;
    logic [7:0]  m_motor_select_direction;
    logic [7:0]  m_received_check;
    logic [7:0]  m_computed_check;
    logic        m_check_ok;
    logic        m_for_this_node;
    logic        m_frame_overflow;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    crc8_packet_receiver #(
        .MAX_FRAME(MAX_FRAME)
    ) u_top (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_rx_byte               (s_rx_byte),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_frame_length          (m_frame_length),
        .m_long_form             (m_long_form),
        .m_master_status         (m_master_status),
        .m_target_address        (m_target_address),
        .m_instruction_code      (m_instruction_code),
        .m_drive_speed           (m_drive_speed),
        .m_motor_select_direction(m_motor_select_direction),
        .m_received_check        (m_received_check),
        .m_computed_check        (m_computed_check),
        .m_check_ok              (m_check_ok),
        .m_for_this_node         (m_for_this_node),
        .m_frame_overflow        (m_frame_overflow),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready)
    );

    // Deframer mirror: register copies and the frame being collected
    logic [7:0] cfg_node;
    logic [7:0] cfg_end;
    logic [7:0] cfg_poly;
    logic [7:0] cfg_init;
    logic [7:0] frame_bytes [KEPT_BYTES];
    int         rx_count;
    int         first_zero_at;
    bit         zero_found;
    bit         count_capped;

    frame_result_t pending_frames [$];
    int            fail_count;
    int            cycle_count;
    int            bytes_sent;
    bit            tx_idle_on;
    bit            rx_idle_on;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // lone end byte straight after reset: every other position reads zero
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hC0, 1'b1,
          '{5'd1, 1'b0, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0}},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h80, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h10, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h01, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h22, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h33, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h5A, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hC0, 1'b0, '0},
        // bytes after a zero are kept, length stops at the zero
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h01, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h00, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h22, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h33, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hC0, 1'b1,
          '{5'd1, 1'b0, 8'h01, 8'h00, 8'h22, 8'h00, 8'h00, 8'h33, 8'h00, 1'b0, 1'b0, 1'b0}},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h10, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hC0, 1'b0, '0},
        '{ROW_CFG, crc8pr_pkg::REG_NODE_ADDRESS,     8'hFF, 1'b0, '0},
        '{ROW_CFG, crc8pr_pkg::REG_FRAME_END_BYTE,   8'h00, 1'b0, '0},
        '{ROW_CFG, crc8pr_pkg::REG_CHECK_POLYNOMIAL, 8'hFF, 1'b0, '0},
        '{ROW_CFG, crc8pr_pkg::REG_CHECK_INITIAL,    8'hFF, 1'b0, '0},
        // zero end byte: it is its own first zero, at position 0
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h00, 1'b1,
          '{5'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0}},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h11, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hFF, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h01, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h80, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h3C, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hAA, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'h00, 1'b0, '0},
        '{ROW_CFG, crc8pr_pkg::REG_NODE_ADDRESS,     8'h00, 1'b0, '0},
        '{ROW_CFG, crc8pr_pkg::REG_FRAME_END_BYTE,   8'hFF, 1'b0, '0},
        '{ROW_CFG, crc8pr_pkg::REG_CHECK_POLYNOMIAL, 8'h00, 1'b0, '0},
        '{ROW_CFG, crc8pr_pkg::REG_CHECK_INITIAL,    8'h00, 1'b0, '0},
        '{ROW_BYTE, crc8pr_pkg::REG_NODE_ADDRESS, 8'hFF, 1'b1,
          '{5'd1, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0}}
    };

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        c = acc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ cfg_poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Covered bytes: address, instruction and, in long form, select/direction.
    // A zero byte halts coverage for the rest of the frame.
    function automatic logic [7:0] frame_crc(input logic [7:0] addr, input logic [7:0] instr,
                                             input logic [7:0] seldir, input bit is_long);
        logic [7:0] cov [3];
        logic [7:0] acc;
        bit         halted;
        int         n;
        cov[0] = addr;
        cov[1] = instr;
        cov[2] = seldir;
        n      = is_long ? 3 : 2;
        acc    = cfg_init;
        halted = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (cov[i] == 8'h00) begin
                halted = 1'b1;
            end
            if (!halted) begin
                acc = crc8_step(acc, cov[i]);
            end
        end
        return acc;
    endfunction

    task automatic absorb_rx_byte(input logic [7:0] b, output bit closed,
                                  output frame_result_t r);
        int len;
        bit is_long;
        closed = 1'b0;
        r      = '0;
        if (rx_count < KEPT_BYTES) begin
            frame_bytes[rx_count] = b;
        end
        if (b == 8'h00 && !zero_found) begin
            zero_found    = 1'b1;
            first_zero_at = rx_count;
        end
        if (rx_count < MAX_FRAME) begin
            rx_count++;
        end else begin
            count_capped = 1'b1;
        end
        if (b == cfg_end) begin
            len     = zero_found ? first_zero_at : rx_count;
            is_long = (len == LONG_FRAME);
            r.frame_length           = len[4:0];
            r.long_form              = is_long;
            r.master_status          = frame_bytes[0];
            r.target_address         = frame_bytes[1];
            r.instruction_code       = frame_bytes[2];
            r.drive_speed            = is_long ? frame_bytes[3] : 8'h00;
            r.motor_select_direction = is_long ? frame_bytes[4] : 8'h00;
            r.received_check         = is_long ? frame_bytes[5] : frame_bytes[3];
            r.computed_check         = frame_crc(frame_bytes[1], frame_bytes[2],
                                                 r.motor_select_direction, is_long);
            r.check_ok               = (r.received_check == r.computed_check);
            r.for_this_node          = (frame_bytes[1] == cfg_node);
            r.frame_overflow         = count_capped;
            closed = 1'b1;
            // start the next frame from a clean store
            foreach (frame_bytes[i]) begin
                frame_bytes[i] = 8'h00;
            end
            rx_count      = 0;
            first_zero_at = 0;
            zero_found    = 1'b0;
            count_capped  = 1'b0;
        end
    endtask

    task automatic pause_sender(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic feed_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
        bit            closed;
        frame_result_t r;
        if (tx_idle_on && $urandom_range(0, 9) == 0) begin
            pause_sender($urandom_range(1, 19));
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        absorb_rx_byte(b, closed, r);
        if (closed) begin
            pending_frames.push_back(typed ? want : r);
        end
    endtask

    // Hold the sender until every frame result is out, then let the pipeline settle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input crc8pr_pkg::reg_index_t idx, input logic [7:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, v};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            crc8pr_pkg::REG_NODE_ADDRESS:     cfg_node = v;
            crc8pr_pkg::REG_FRAME_END_BYTE:   cfg_end  = v;
            crc8pr_pkg::REG_CHECK_POLYNOMIAL: cfg_poly = v;
            crc8pr_pkg::REG_CHECK_INITIAL:    cfg_init = v;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input crc8pr_pkg::reg_index_t idx, input logic [7:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {24'h0, want}) begin
            $error("prdata[%s]: expected %0h, got %0h", idx.name(), want, prdata);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] node, input logic [7:0] fend,
                                input logic [7:0] poly, input logic [7:0] init);
        apb_write(crc8pr_pkg::REG_NODE_ADDRESS, node);
        apb_write(crc8pr_pkg::REG_FRAME_END_BYTE, fend);
        apb_write(crc8pr_pkg::REG_CHECK_POLYNOMIAL, poly);
        apb_write(crc8pr_pkg::REG_CHECK_INITIAL, init);
        apb_read_check(crc8pr_pkg::REG_NODE_ADDRESS, node);
        apb_read_check(crc8pr_pkg::REG_FRAME_END_BYTE, fend);
        apb_read_check(crc8pr_pkg::REG_CHECK_POLYNOMIAL, poly);
        apb_read_check(crc8pr_pkg::REG_CHECK_INITIAL, init);
    endtask

    // Frame body byte that does not close the frame early
    function automatic logic [7:0] body_byte(input bit zero_ok);
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while (v == cfg_end || (!zero_ok && v == 8'h00));
        return v;
    endfunction

    task automatic send_random_frame();
        logic [7:0] seq [$];
        logic [7:0] ad;
        logic [7:0] ins;
        logic [7:0] sd;
        logic [7:0] chk;
        int         pick;
        int         n;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            ad  = $urandom_range(0, 1) ? cfg_node : body_byte(1'b0);
            ins = body_byte(1'b0);
            sd  = body_byte(1'b0);
            seq.push_back(body_byte(1'b0));
            seq.push_back(ad);
            seq.push_back(ins);
            if (pick < 40) begin
                chk = frame_crc(ad, ins, sd, 1'b1);
                seq.push_back(body_byte(1'b0));
                seq.push_back(sd);
            end else begin
                chk = frame_crc(ad, ins, 8'h00, 1'b0);
            end
            // corrupt the check byte now and then
            if ($urandom_range(0, 3) == 0) begin
                chk = body_byte(1'b1);
            end
            seq.push_back(chk);
            if (pick < 40) begin
                seq.push_back(body_byte(1'b0));
            end
        end else if (pick < 70) begin
            n = $urandom_range(0, 8);
            repeat (n) seq.push_back(body_byte(1'b0));
        end else if (pick < 78) begin
            // run close to or past the frame limit
            n = $urandom_range(14, 22);
            repeat (n) seq.push_back(body_byte(1'b1));
        end else if (pick < 90) begin
            n = $urandom_range(1, 9);
            repeat (n) seq.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : body_byte(1'b1));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) seq.push_back(8'($urandom_range(0, 255)));
        end
        if (pick < 90) begin
            seq.push_back(cfg_end);
        end
        foreach (seq[i]) begin
            feed_byte(seq[i], 1'b0, '0);
        end
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                $error("result beat with no frame pending");
                fail_count++;
            end else begin
                want = pending_frames.pop_front();
                check_field("frame_length", 8'(want.frame_length), 8'(m_frame_length));
                check_field("long_form", 8'(want.long_form), 8'(m_long_form));
                check_field("master_status", want.master_status, m_master_status);
                check_field("target_address", want.target_address, m_target_address);
                check_field("instruction_code", want.instruction_code, m_instruction_code);
                check_field("drive_speed", want.drive_speed, m_drive_speed);
                check_field("motor_select_direction", want.motor_select_direction,
                            m_motor_select_direction);
                check_field("received_check", want.received_check, m_received_check);
                check_field("computed_check", want.computed_check, m_computed_check);
                check_field("check_ok", 8'(want.check_ok), 8'(m_check_ok));
                check_field("for_this_node", 8'(want.for_this_node), 8'(m_for_this_node));
                check_field("frame_overflow", 8'(want.frame_overflow), 8'(m_frame_overflow));
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_rx_byte   = 8'h00;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        fail_count  = 0;
        cycle_count = 0;
        bytes_sent  = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        cfg_node    = 8'd16;
        cfg_end     = 8'd192;
        cfg_poly    = 8'd7;
        cfg_init    = 8'd0;
        foreach (frame_bytes[i]) begin
            frame_bytes[i] = 8'h00;
        end
        rx_count      = 0;
        first_zero_at = 0;
        zero_found    = 1'b0;
        count_capped  = 1'b0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                apb_write(directed_rows[i].reg_sel, directed_rows[i].data);
            end else begin
                feed_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0:       apply_config(8'h10, 8'hC0, 8'h07, 8'h00);
                1:       apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                2:       apply_config(8'h00, 8'h00, 8'h00, 8'h00);
                default: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            // the final phase runs both sides flat out
            tx_idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            begin
                int target;
                target = bytes_sent + BYTES_PER_PHASE;
                while (bytes_sent < target) send_random_frame();
            end
        end

        wait_idle();
        if (fail_count == 0 && pending_frames.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
